>>> rtl/assert_macros.svh
// assertion macros shared by the projective box transform rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define HBT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hbt assertion failed");

// checked on every rising clock edge, reset included
`define HBT_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("hbt assertion failed");

`endif

>>> rtl/hbt_pkg.sv
// shared types and constants of the projective box transform
package hbt_pkg;

	localparam int COEF_W              = 48;
	localparam int COORD_W             = 32;
	localparam int SPLIT_W             = 24;
	localparam int NUM_COEF            = 9;
	localparam int NUM_CORNER          = 4;
	localparam int NUM_FORM            = 3;
	localparam int COORD_FRAC_BITS_DEF = 16;

	// linear form indexes
	localparam int FORM_X = 0;
	localparam int FORM_Y = 1;
	localparam int FORM_D = 2;

	localparam int PROD_W = COEF_W + COORD_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int QUOT_W = 32;
	localparam int REM_W  = SUM_W + QUOT_W;

	// divider: magnitude, init, one stage per quotient bit, saturate
	localparam int DIV_LAT = QUOT_W + 3;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	localparam int IDX_W = 2;

	localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_BOX_LEFT,
		REG_BOX_TOP,
		REG_BOX_RIGHT,
		REG_BOX_BOTTOM
	} reg_idx_t;

	// one queued transaction: homography plus the four rectangle corners
	typedef struct packed {
		logic [NUM_COEF-1:0][COEF_W-1:0]    h;
		logic [NUM_CORNER-1:0][COORD_W-1:0] cx;
		logic [NUM_CORNER-1:0][COORD_W-1:0] cy;
	} item_t;

	typedef struct packed {
		logic nneg;
		logic qneg;
		logic nzero;
		logic dzero;
		logic ovf;
	} div_flags_t;

endpackage

>>> rtl/hbt_front.sv
// front end: config registers, input acceptance and corner expansion
module hbt_front (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     wr_en,
	input  logic [hbt_pkg::IDX_W-1:0]                                wr_index,
	input  logic [hbt_pkg::COORD_W-1:0]                              wr_data,
	input  logic                                                     item_valid,
	output logic                                                     item_ready,
	input  logic [hbt_pkg::NUM_COEF-1:0][hbt_pkg::COEF_W-1:0]        h_in,
	output logic                                                     push_valid,
	input  logic                                                     push_ready,
	output hbt_pkg::item_t                                           push_item
);

	logic [hbt_pkg::COORD_W-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;
	logic                        valid_q;
	hbt_pkg::item_t              item_q;
	logic                        take;

	// rectangle registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				hbt_pkg::REG_BOX_LEFT:   box_left_q   <= wr_data;
				hbt_pkg::REG_BOX_TOP:    box_top_q    <= wr_data;
				hbt_pkg::REG_BOX_RIGHT:  box_right_q  <= wr_data;
				hbt_pkg::REG_BOX_BOTTOM: box_bottom_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign item_ready = !valid_q || push_ready;
	assign take       = item_valid && item_ready;

	// holding register in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= take || (valid_q && !push_ready);
		end
	end

	// corners in order top-left, top-right, bottom-right, bottom-left
	always_ff @(posedge clk) begin
		if (take) begin
			item_q.h     <= h_in;
			item_q.cx[0] <= box_left_q;
			item_q.cy[0] <= box_top_q;
			item_q.cx[1] <= box_right_q;
			item_q.cy[1] <= box_top_q;
			item_q.cx[2] <= box_right_q;
			item_q.cy[2] <= box_bottom_q;
			item_q.cx[3] <= box_left_q;
			item_q.cy[3] <= box_bottom_q;
		end
	end

	assign push_valid = valid_q;
	assign push_item  = item_q;

endmodule

>>> rtl/hbt_fifo.sv
// short queue between front end and compute pipeline
`include "assert_macros.svh"

module hbt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  hbt_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output hbt_pkg::item_t pop_item
);

	hbt_pkg::item_t                   mem_q [hbt_pkg::FIFO_DEPTH];
	logic [hbt_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [hbt_pkg::FIFO_CNT_W-1:0]   count_q;
	logic                             do_push, do_pop;

	assign push_ready = count_q != hbt_pkg::FIFO_CNT_W'(hbt_pkg::FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`HBT_ASSERT_ALWAYS(a_count_max, (count_q <= hbt_pkg::FIFO_CNT_W'(hbt_pkg::FIFO_DEPTH)))
	`HBT_ASSERT(a_count_up, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
	`HBT_ASSERT(a_count_down, (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))

endmodule

>>> rtl/hbt_div.sv
// pipelined signed divider with saturation, one quotient bit per stage
module hbt_div #(
	parameter int COORD_FRAC_BITS = hbt_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [hbt_pkg::SUM_W-1:0]    num,
	input  logic signed [hbt_pkg::SUM_W-1:0]    den,
	output logic        [hbt_pkg::COORD_W-1:0]  quot,
	output logic                                fault
);

	localparam int SW = hbt_pkg::SUM_W;
	localparam int RW = hbt_pkg::REM_W;
	localparam int QW = hbt_pkg::QUOT_W;

	logic [SW-1:0]           nmag_s1, dmag_s1;
	hbt_pkg::div_flags_t     flg_s1;
	hbt_pkg::div_flags_t     flg_init;
	logic [RW-1:0]           rem_q  [QW];
	logic [SW-1:0]           dmag_q [QW];
	logic [QW-1:0]           quo_q  [QW+1];
	hbt_pkg::div_flags_t     flg_q  [QW+1];
	logic [QW-1:0]           q_fin;
	hbt_pkg::div_flags_t     f_fin;

	// magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1      <= num[SW-1] ? SW'(-num) : SW'(num);
			dmag_s1      <= den[SW-1] ? SW'(-den) : SW'(den);
			flg_s1.nneg  <= num[SW-1];
			flg_s1.qneg  <= num[SW-1] ^ den[SW-1];
			flg_s1.nzero <= num == '0;
			flg_s1.dzero <= den == '0;
			flg_s1.ovf   <= 1'b0;
		end
	end

	// flag quotients of 2^32 and more
	always_comb begin
		flg_init     = flg_s1;
		flg_init.ovf = (RW'(nmag_s1) << COORD_FRAC_BITS) >= (RW'(dmag_s1) << QW);
	end

	// scale numerator
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= RW'(nmag_s1) << COORD_FRAC_BITS;
			dmag_q[0] <= dmag_s1;
			quo_q[0]  <= '0;
			flg_q[0]  <= flg_init;
		end
	end

	// restoring division, most significant bit first
	for (genvar j = 0; j < QW; j++) begin : g_iter
		logic [RW-1:0] dsh;
		logic          fit;
		assign dsh = RW'(dmag_q[j]) << (QW - 1 - j);
		assign fit = rem_q[j] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[j+1] <= fit ? (quo_q[j] | (QW'(1) << (QW - 1 - j))) : quo_q[j];
				flg_q[j+1] <= flg_q[j];
			end
		end

		if (j < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j+1]  <= fit ? rem_q[j] - dsh : rem_q[j];
					dmag_q[j+1] <= dmag_q[j];
				end
			end
		end
	end

	assign q_fin = quo_q[QW];
	assign f_fin = flg_q[QW];

	// zero divisor and range saturation
	always_ff @(posedge clk) begin
		if (en) begin
			if (f_fin.dzero) begin
				fault <= 1'b1;
				quot  <= f_fin.nzero ? '0 : (f_fin.nneg ? hbt_pkg::SAT_MIN : hbt_pkg::SAT_MAX);
			end else if (f_fin.ovf || (f_fin.qneg ? (q_fin[QW-1] && (q_fin[QW-2:0] != '0))
					: q_fin[QW-1])) begin
				fault <= 1'b1;
				quot  <= f_fin.qneg ? hbt_pkg::SAT_MIN : hbt_pkg::SAT_MAX;
			end else begin
				fault <= 1'b0;
				quot  <= f_fin.qneg ? -q_fin : q_fin;
			end
		end
	end

endmodule

>>> rtl/hbt_back.sv
// compute pipeline: linear forms, perspective division, bounding box
`include "assert_macros.svh"

module hbt_back #(
	parameter int COORD_FRAC_BITS = hbt_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  hbt_pkg::item_t                      pop_item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_left,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_top,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_right,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_bottom,
	output logic                                range_fault
);

	localparam int NC     = hbt_pkg::NUM_CORNER;
	localparam int NF     = hbt_pkg::NUM_FORM;
	localparam int SW     = hbt_pkg::SUM_W;
	localparam int CW     = hbt_pkg::COORD_W;
	localparam int SPL    = hbt_pkg::SPLIT_W;
	localparam int HI_W   = hbt_pkg::COEF_W - SPL + CW;
	localparam int LO_W   = SPL + 1 + CW;
	localparam int STAGES = hbt_pkg::DIV_LAT + 5;
	localparam int LAST   = STAGES - 1;

	logic [STAGES-1:0]           v_q;
	logic                        en;

	logic signed [HI_W-1:0]      pxh_s1 [NC][NF];
	logic signed [LO_W-1:0]      pxl_s1 [NC][NF];
	logic signed [HI_W-1:0]      pyh_s1 [NC][NF];
	logic signed [LO_W-1:0]      pyl_s1 [NC][NF];
	logic [hbt_pkg::COEF_W-1:0]  c0_s1  [NF];
	logic signed [SW-1:0]        tx_s2  [NC][NF];
	logic signed [SW-1:0]        ty_s2  [NC][NF];
	logic [hbt_pkg::COEF_W-1:0]  c0_s2  [NF];
	logic signed [SW-1:0]        lin_s3 [NC][NF];
	logic signed [CW-1:0]        qt     [NC][2];
	logic                        ft     [NC][2];
	logic signed [CW-1:0]        lox_s4 [2];
	logic signed [CW-1:0]        hix_s4 [2];
	logic signed [CW-1:0]        loy_s4 [2];
	logic signed [CW-1:0]        hiy_s4 [2];
	logic                        flt_s4;

	// the whole pipeline moves unless the output register is held
	assign en        = !v_q[LAST] || result_ready;
	assign pop_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAST-1:0], pop_valid};
		end
	end

	// partial products, coefficient split into signed high and unsigned low halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				for (int f = 0; f < NF; f++) begin
					pxh_s1[k][f] <= $signed(pop_item.h[3*f][hbt_pkg::COEF_W-1:SPL])
						* $signed(pop_item.cx[k]);
					pxl_s1[k][f] <= $signed({1'b0, pop_item.h[3*f][SPL-1:0]})
						* $signed(pop_item.cx[k]);
					pyh_s1[k][f] <= $signed(pop_item.h[3*f+1][hbt_pkg::COEF_W-1:SPL])
						* $signed(pop_item.cy[k]);
					pyl_s1[k][f] <= $signed({1'b0, pop_item.h[3*f+1][SPL-1:0]})
						* $signed(pop_item.cy[k]);
				end
			end
			for (int f = 0; f < NF; f++) begin
				c0_s1[f] <= pop_item.h[3*f+2];
			end
		end
	end

	// recombine the halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				for (int f = 0; f < NF; f++) begin
					tx_s2[k][f] <= (SW'(pxh_s1[k][f]) <<< SPL) + SW'(pxl_s1[k][f]);
					ty_s2[k][f] <= (SW'(pyh_s1[k][f]) <<< SPL) + SW'(pyl_s1[k][f]);
				end
			end
			c0_s2 <= c0_s1;
		end
	end

	// linear forms with the offset term aligned to the product scale
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				for (int f = 0; f < NF; f++) begin
					lin_s3[k][f] <= tx_s2[k][f] + ty_s2[k][f]
						+ (SW'($signed(c0_s2[f])) <<< COORD_FRAC_BITS);
				end
			end
		end
	end

	// eight dividers, x and y of each corner share the denominator
	for (genvar k = 0; k < NC; k++) begin : g_corner
		for (genvar a = 0; a < 2; a++) begin : g_axis
			hbt_div #(
				.COORD_FRAC_BITS(COORD_FRAC_BITS)
			) u_div (
				.clk   (clk),
				.en    (en),
				.num   (lin_s3[k][a]),
				.den   (lin_s3[k][hbt_pkg::FORM_D]),
				.quot  (qt[k][a]),
				.fault (ft[k][a])
			);
		end
	end

	// min and max over corner pairs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 2; p++) begin
				lox_s4[p] <= (qt[2*p][hbt_pkg::FORM_X] < qt[2*p+1][hbt_pkg::FORM_X])
					? qt[2*p][hbt_pkg::FORM_X] : qt[2*p+1][hbt_pkg::FORM_X];
				hix_s4[p] <= (qt[2*p][hbt_pkg::FORM_X] > qt[2*p+1][hbt_pkg::FORM_X])
					? qt[2*p][hbt_pkg::FORM_X] : qt[2*p+1][hbt_pkg::FORM_X];
				loy_s4[p] <= (qt[2*p][hbt_pkg::FORM_Y] < qt[2*p+1][hbt_pkg::FORM_Y])
					? qt[2*p][hbt_pkg::FORM_Y] : qt[2*p+1][hbt_pkg::FORM_Y];
				hiy_s4[p] <= (qt[2*p][hbt_pkg::FORM_Y] > qt[2*p+1][hbt_pkg::FORM_Y])
					? qt[2*p][hbt_pkg::FORM_Y] : qt[2*p+1][hbt_pkg::FORM_Y];
			end
			flt_s4 <= ft[0][0] | ft[0][1] | ft[1][0] | ft[1][1]
				| ft[2][0] | ft[2][1] | ft[3][0] | ft[3][1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_left    <= (lox_s4[0] < lox_s4[1]) ? lox_s4[0] : lox_s4[1];
			out_right   <= (hix_s4[0] > hix_s4[1]) ? hix_s4[0] : hix_s4[1];
			out_top     <= (loy_s4[0] < loy_s4[1]) ? loy_s4[0] : loy_s4[1];
			out_bottom  <= (hiy_s4[0] > hiy_s4[1]) ? hiy_s4[0] : hiy_s4[1];
			range_fault <= flt_s4;
		end
	end

	assign result_valid = v_q[LAST];

	`HBT_ASSERT(a_stall_freezes, (result_valid && !result_ready) |=> $stable(v_q))
	`HBT_ASSERT(a_out_from_pipe, $rose(result_valid) |-> $past(v_q[LAST-1]))
	`HBT_ASSERT(a_pop_only_moving, (pop_valid && pop_ready) |=> v_q[0])

endmodule

>>> rtl/homography_box_transform.sv
// top level of the projective box transform
//
// Input channel item_valid/item_ready carries one 3x3 homography (h_00..h_22,
// signed Q16.32) per transaction. Result channel result_valid/result_ready
// returns one transaction per input: the bounding box of the four projected
// rectangle corners (signed Q16.16) and range_fault.
// The rectangle sits in four registers written through wr_en/wr_index/wr_data
// (left, top, right, bottom; reset to zero). Write them only while idle.
// From the accepting edge to result_valid a transaction passes the holding
// register, which loads at that edge, then one queue slot, three multiply/add
// stages, 35 divider stages (one quotient bit per stage), one min/max stage
// and the output register. The dividers are fully pipelined.
// Throughput is one transaction per cycle while no result is held.
// A held result freezes the compute pipeline; the holding register and queue
// keep taking transactions until both are full, then item_ready drops.
// Reset clears the rectangle registers, queue and all valid flags.
module homography_box_transform #(
	parameter int COORD_FRAC_BITS = hbt_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [hbt_pkg::IDX_W-1:0]           wr_index,
	input  logic [hbt_pkg::COORD_W-1:0]         wr_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_00,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_01,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_02,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_10,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_11,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_12,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_20,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_21,
	input  logic signed [hbt_pkg::COEF_W-1:0]   h_22,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_left,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_top,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_right,
	output logic signed [hbt_pkg::COORD_W-1:0]  out_bottom,
	output logic                                range_fault
);

	logic [hbt_pkg::NUM_COEF-1:0][hbt_pkg::COEF_W-1:0] h_in;
	logic           push_valid, push_ready, pop_valid, pop_ready;
	hbt_pkg::item_t push_item, pop_item;

	// row-major coefficient vector, h_00 at index zero
	assign h_in = {h_22, h_21, h_20, h_12, h_11, h_10, h_02, h_01, h_00};

	hbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.h_in       (h_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	hbt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	hbt_back #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_left     (out_left),
		.out_top      (out_top),
		.out_right    (out_right),
		.out_bottom   (out_bottom),
		.range_fault  (range_fault)
	);

endmodule
